FILE: rtl/core/lwfs_pkg.sv
// ----------------------------------------------------------------------------
// lwfs_pkg
// Shared types and constants for the forward lifting wavelet step.
// ----------------------------------------------------------------------------
package lwfs_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int COEF_W              = 24;
    localparam int COEF_MAX            = 8388607;
    localparam int COEF_MIN            = -8388608;
    localparam int FLUSH_PAIRS         = 4;
    localparam int FLUSH_CNT_W         = $clog2(FLUSH_PAIRS + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_sample;
    } sample_req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] approx;
        logic signed [COEF_W-1:0] detail;
        logic                     final_pair;
    } coef_req_t;

    typedef struct packed {
        logic valid;
        logic fin;
    } pair_ctrl_t;

endpackage

FILE: rtl/core/lifting_wavelet_forward_step.sv
// ----------------------------------------------------------------------------
// lifting_wavelet_forward_step
// Forward lifting wavelet step: 4-tap predict, 2-tap update, 6 fraction bits.
//
//   channel  signals                                  moves
//   -------  ---------------------------------------  ------------------------
//   sample   sample_valid / sample_ready / sample_data one sample per request
//   coef     coef_valid / coef_ready / coef_data       one coefficient pair
//
// One sample is taken per cycle while sample_ready is high. An odd sample (or
// an even final sample) completes a pair in the input register; once no flush
// runs and the output register is free, the datapath produces one pair into
// it. A final sample adds four flush pairs, one per cycle unless coef stalls;
// meanwhile the samples of the next pair can be taken, and that pair waits in
// the input register until the flush ends. Reset clears all history; a
// stalled coef channel stalls the datapath and then the sample channel.
// ----------------------------------------------------------------------------
module lifting_wavelet_forward_step #(
    parameter int SAMPLE_BITS = lwfs_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  lwfs_pkg::sample_req_t sample_data,
    output logic                  coef_valid,
    input  logic                  coef_ready,
    output lwfs_pkg::coef_req_t   coef_data
);
    import lwfs_pkg::*;

    logic [SAMPLE_BITS-1:0]        raw;
    logic signed [SAMPLE_BITS-1:0] s_val;
    logic                          accept;
    logic                          load;
    logic                          pair_take;
    pair_ctrl_t                    pair_ctrl;

    logic                          phase_odd_reg, phase_odd_next;
    logic signed [SAMPLE_BITS-1:0] held_even_reg, held_even_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_fin_reg, s1_fin_next;
    logic signed [SAMPLE_BITS-1:0] s1_even_reg, s1_even_next;
    logic signed [SAMPLE_BITS-1:0] s1_odd_reg, s1_odd_next;

    if (SAMPLE_BITS <= SAMPLE_W)
    begin : g_trunc
        assign raw = sample_data.sample[SAMPLE_BITS-1:0];
    end
    else
    begin : g_ext
        assign raw = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, sample_data.sample};
    end

    assign s_val        = signed'(raw);
    assign sample_ready = !s1_valid_reg || pair_take;
    assign accept       = sample_valid && sample_ready;
    assign load         = accept && (phase_odd_reg || sample_data.final_sample);

    always_comb
    begin
        phase_odd_next = phase_odd_reg;
        held_even_next = held_even_reg;
        s1_valid_next  = s1_valid_reg && !pair_take;
        s1_fin_next    = s1_fin_reg;
        s1_even_next   = s1_even_reg;
        s1_odd_next    = s1_odd_reg;
        if (accept && !load)
        begin
            held_even_next = s_val;
            phase_odd_next = 1'b1;
        end
        if (load)
        begin
            s1_valid_next  = 1'b1;
            s1_fin_next    = sample_data.final_sample;
            s1_even_next   = phase_odd_reg ? held_even_reg : s_val;
            s1_odd_next    = phase_odd_reg ? s_val : '0;
            phase_odd_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_odd_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_odd_reg <= phase_odd_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_even_reg <= held_even_next;
        s1_fin_reg    <= s1_fin_next;
        s1_even_reg   <= s1_even_next;
        s1_odd_reg    <= s1_odd_next;
    end

    assign pair_ctrl.valid = s1_valid_reg;
    assign pair_ctrl.fin   = s1_fin_reg;

    lwfs_lift_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lift_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_ctrl  (pair_ctrl),
        .pair_even  (s1_even_reg),
        .pair_odd   (s1_odd_reg),
        .pair_take  (pair_take),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef_data  (coef_data)
    );

endmodule

FILE: rtl/core/lwfs_lift_core.sv
// ----------------------------------------------------------------------------
// lwfs_lift_core
// Predict/update datapath with sample history, flush sequencing and the
// registered coefficient output.
// ----------------------------------------------------------------------------
module lwfs_lift_core #(
    parameter int SAMPLE_BITS = lwfs_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lwfs_pkg::pair_ctrl_t          pair_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] pair_even,
    input  logic signed [SAMPLE_BITS-1:0] pair_odd,
    output logic                          pair_take,
    output logic                          coef_valid,
    input  logic                          coef_ready,
    output lwfs_pkg::coef_req_t           coef_data
);
    import lwfs_pkg::*;

    localparam int DW = SAMPLE_BITS + 6;
    localparam int RW = SAMPLE_BITS + 8;
    localparam int SW = (RW > COEF_W) ? RW : COEF_W;
    localparam logic [FLUSH_CNT_W-1:0] FLUSH_LOAD = FLUSH_CNT_W'(FLUSH_PAIRS);
    localparam logic [FLUSH_CNT_W-1:0] FLUSH_LAST = FLUSH_CNT_W'(1);

    logic signed [SW-1:0] sat_max;
    logic signed [SW-1:0] sat_min;

    logic signed [SAMPLE_BITS-1:0] eh0_reg, eh1_reg, eh2_reg;
    logic signed [SAMPLE_BITS-1:0] oh0_reg, oh1_reg;
    logic signed [DW-1:0]          prev_reg;
    logic [FLUSH_CNT_W-1:0]        flush_cnt_reg;
    logic                          coef_valid_reg;
    coef_req_t                     coef_data_reg;

    logic signed [SAMPLE_BITS-1:0] eh0_next, eh1_next, eh2_next;
    logic signed [SAMPLE_BITS-1:0] oh0_next, oh1_next;
    logic signed [DW-1:0]          prev_next;
    logic [FLUSH_CNT_W-1:0]        flush_cnt_next;
    logic                          coef_valid_next;
    coef_req_t                     coef_data_next;

    logic                          flushing;
    logic                          out_free;
    logic                          step;
    logic signed [SAMPLE_BITS-1:0] op_even;
    logic signed [SAMPLE_BITS-1:0] op_odd;
    logic signed [DW-1:0]          pair_sum;
    logic signed [DW-1:0]          dq;
    logic signed [RW-1:0]          approx_full;
    logic signed [RW-1:0]          detail_full;

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > sat_max)
        begin
            r = sat_max;
        end
        else if (v < sat_min)
        begin
            r = sat_min;
        end
        return r[COEF_W-1:0];
    endfunction

    assign sat_max = SW'(COEF_MAX);
    assign sat_min = SW'(COEF_MIN);

    assign flushing  = (flush_cnt_reg != '0);
    assign out_free  = !coef_valid_reg || coef_ready;
    assign pair_take = pair_ctrl.valid && !flushing && out_free;
    assign step      = pair_take || (flushing && out_free);
    assign op_even   = flushing ? '0 : pair_even;
    assign op_odd    = flushing ? '0 : pair_odd;

    // D in 1/16 units, A' in 1/64 units
    assign pair_sum    = DW'(eh1_reg) + DW'(eh0_reg);
    assign dq          = (DW'(oh1_reg) <<< 4) - ((pair_sum <<< 3) + pair_sum)
                         + DW'(eh2_reg) + DW'(op_even);
    assign approx_full = (RW'(eh1_reg) <<< 6) + RW'(prev_reg) + RW'(dq);
    assign detail_full = RW'(prev_reg) <<< 2;

    always_comb
    begin
        eh0_next        = eh0_reg;
        eh1_next        = eh1_reg;
        eh2_next        = eh2_reg;
        oh0_next        = oh0_reg;
        oh1_next        = oh1_reg;
        prev_next       = prev_reg;
        flush_cnt_next  = flush_cnt_reg;
        coef_valid_next = coef_valid_reg && !coef_ready;
        coef_data_next  = coef_data_reg;
        if (step)
        begin
            eh2_next        = eh1_reg;
            eh1_next        = eh0_reg;
            eh0_next        = op_even;
            oh1_next        = oh0_reg;
            oh0_next        = op_odd;
            prev_next       = dq;
            coef_valid_next = 1'b1;
            coef_data_next.approx     = sat_coef(SW'(approx_full));
            coef_data_next.detail     = sat_coef(SW'(detail_full));
            coef_data_next.final_pair = flushing && (flush_cnt_reg == FLUSH_LAST);
            if (pair_take && pair_ctrl.fin)
            begin
                flush_cnt_next = FLUSH_LOAD;
            end
            if (flushing)
            begin
                flush_cnt_next = flush_cnt_reg - FLUSH_LAST;
                if (flush_cnt_reg == FLUSH_LAST)
                begin
                    eh0_next  = '0;
                    eh1_next  = '0;
                    eh2_next  = '0;
                    oh0_next  = '0;
                    oh1_next  = '0;
                    prev_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eh0_reg        <= '0;
            eh1_reg        <= '0;
            eh2_reg        <= '0;
            oh0_reg        <= '0;
            oh1_reg        <= '0;
            prev_reg       <= '0;
            flush_cnt_reg  <= '0;
            coef_valid_reg <= 1'b0;
        end
        else
        begin
            eh0_reg        <= eh0_next;
            eh1_reg        <= eh1_next;
            eh2_reg        <= eh2_next;
            oh0_reg        <= oh0_next;
            oh1_reg        <= oh1_next;
            prev_reg       <= prev_next;
            flush_cnt_reg  <= flush_cnt_next;
            coef_valid_reg <= coef_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_data_reg <= coef_data_next;
    end

    assign coef_valid = coef_valid_reg;
    assign coef_data  = coef_data_reg;

endmodule
